[hw/rtl/cms_pkg.sv]
// Shared constants and types of the column min-max scaler.
package cms_pkg;

   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_MAX_COLUMNS = 16;

   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 16;
   localparam int SCALED_W   = 17;
   localparam int COL_OUT_W  = 4;
   localparam int CFG_W      = 5;
   localparam int QUO_W      = 16;
   localparam int APB_DATA_W = 32;
   localparam int PADDR_W    = 3;

   localparam logic [SCALED_W-1:0] SCALED_ONE = SCALED_W'(1) << QUO_W;
   localparam logic [CFG_W-1:0]    NUM_COLUMNS_RESET = CFG_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_PULL  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic [0:0] REG_NUM_COLUMNS = 1'b0;

endpackage

[hw/rtl/cms_if.sv]
// Valid/ready channel interfaces for request and response beats.
interface cms_req_if;
   logic                                valid;
   logic                                ready;
   logic [cms_pkg::CMD_W-1:0]           cmd;
   logic signed [cms_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, cmd, sample, input ready);
   modport sink (input valid, cmd, sample, output ready);
endinterface

interface cms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cms_pkg::SCALED_W-1:0]      scaled;
   logic [cms_pkg::COL_OUT_W-1:0]     column;
   logic                              last;
   logic                              flat_column;
   logic                              empty_res;
   logic                              overflowed;

   modport source (output valid, scaled, column, last, flat_column, empty_res, overflowed,
                   input ready);
   modport sink (input valid, scaled, column, last, flat_column, empty_res, overflowed,
                 output ready);
endinterface

[hw/rtl/cms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/cms_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, remainder below divisor.
module cms_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cms_pkg::QUO_W-1:0]   num,
   input  logic [cms_pkg::QUO_W-1:0]   den,
   output logic                        busy,
   output logic                        done,
   output logic [cms_pkg::QUO_W-1:0]   quo
);

   localparam int QW = cms_pkg::QUO_W;
   localparam int NW = $clog2(QW + 1);

   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] den_ff, den_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [QW:0]   shifted;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         cnt_in  = NW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? QW'(shifted - {1'b0, den_ff}) : shifted[QW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not go busy after start");

endmodule

[hw/rtl/column_min_max_scaler.sv]
// Column min-max scaler: stores a row-major table and returns samples scaled to Q1.16.
//
// Request channel (req_chan): cmd selects push (store sample, fold into its column's
// minimum and maximum), pull (return next stored sample scaled to [0,1]), clear (start a
// new data set) or no operation. Only pull produces a response beat on rsp_chan.
// Configuration: num_columns is written over the APB port at byte address 0; write it
// only while the block is idle.
// Sequencing: a push passes an update state only when its column already holds a sample
// (the column minimum/maximum RAM is read, then written). An empty pull skips to the emit
// state; others pass a compare state and, unless flat or saturated, a divide state for the
// 16-step bit-serial divider, one quotient bit per cycle. One request is processed at a
// time. The response sits in an output register: the next request is accepted while it
// waits, but a following pull holds in its final state until the receiver takes the
// earlier beat.
// Reset empties the data set, clears the overflow flag and sets num_columns to 1; the
// sample and column RAMs are not cleared, since the per-column seen bits and the stored
// count keep unwritten entries from being read.
module column_min_max_scaler #(
   parameter int MAX_SAMPLES = cms_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_COLUMNS = cms_pkg::DEF_MAX_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   cms_req_if.sink                           req_chan,
   cms_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cms_pkg::PADDR_W-1:0]       paddr,
   input  logic [cms_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [cms_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int SW   = cms_pkg::SAMPLE_W;
   localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int NW   = ($clog2(MAX_COLUMNS + 1) > cms_pkg::CFG_W) ?
                         $clog2(MAX_COLUMNS + 1) : cms_pkg::CFG_W;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_PUSH_UPD = 5'b00010,
      ST_PULL_CMP = 5'b00100,
      ST_DIV      = 5'b01000,
      ST_EMIT     = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNTW-1:0]             cnt_ff, cnt_in;
   logic [CNTW-1:0]             rp_ff, rp_in;
   logic [CW-1:0]               wcol_ff, wcol_in;
   logic [CW-1:0]               rcol_ff, rcol_in;
   logic [CW-1:0]               pcol_ff, pcol_in;
   logic                        ovf_ff, ovf_in;
   logic [MAX_COLUMNS-1:0]      seen_ff, seen_in;
   logic [cms_pkg::CFG_W-1:0]   ncol_ff, ncol_in;
   logic [SW-1:0]               x_ff, x_in;
   logic [cms_pkg::SCALED_W-1:0] res_scaled_ff, res_scaled_in;
   logic                        res_last_ff, res_last_in;
   logic                        res_flat_ff, res_flat_in;
   logic                        res_empty_ff, res_empty_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cms_pkg::SCALED_W-1:0] out_scaled_ff, out_scaled_in;
   logic [cms_pkg::COL_OUT_W-1:0] out_col_ff, out_col_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_flat_ff, out_flat_in;
   logic                        out_empty_ff, out_empty_in;
   logic                        out_ovf_ff, out_ovf_in;

   logic                        req_ready;
   logic                        req_accept;
   logic                        cfg_write;
   logic                        cfg_hit;
   logic [NW-1:0]               ncol_ext;
   logic [NW-1:0]               active_cols;

   logic                        st_we;
   logic [SAW-1:0]              st_waddr;
   logic [SW-1:0]               st_wdata;
   logic [SAW-1:0]              st_raddr;
   logic [SW-1:0]               st_rdata;
   logic                        mm_we;
   logic [CW-1:0]               mm_waddr;
   logic [2*SW-1:0]             mm_wdata;
   logic [CW-1:0]               mm_raddr;
   logic [2*SW-1:0]             mm_rdata;

   logic                        dv_start;
   logic [cms_pkg::QUO_W-1:0]   dv_num;
   logic [cms_pkg::QUO_W-1:0]   dv_den;
   logic                        dv_busy;
   logic                        dv_done;
   logic [cms_pkg::QUO_W-1:0]   dv_quo;

   logic signed [SW-1:0]        mm_lo;
   logic signed [SW-1:0]        mm_hi;
   logic signed [SW-1:0]        cur_x;
   logic signed [SW:0]          x_minus_lo;
   logic signed [SW:0]          hi_minus_lo;

   function automatic logic [CW-1:0] next_col(input logic [CW-1:0] c, input logic [NW-1:0] n);
      logic [NW-1:0] s;
      s = NW'(c) + NW'(1);
      return (s >= n) ? '0 : CW'(s);
   endfunction

   cms_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_SAMPLES)
   ) u_sample_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   cms_ram #(
      .WIDTH (2*SW),
      .DEPTH (MAX_COLUMNS)
   ) u_minmax_ram (
      .clock (clock),
      .we    (mm_we),
      .waddr (mm_waddr),
      .wdata (mm_wdata),
      .raddr (mm_raddr),
      .rdata (mm_rdata)
   );

   cms_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .busy  (dv_busy),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign cfg_hit   = (paddr[cms_pkg::PADDR_W-1:2] == cms_pkg::REG_NUM_COLUMNS);
   assign cfg_write = psel && penable && pwrite && cfg_hit;
   assign pready    = 1'b1;
   assign prdata    = cfg_hit ? cms_pkg::APB_DATA_W'(ncol_ff) : '0;

   assign ncol_ext    = NW'(ncol_ff);
   assign active_cols = (ncol_ff == '0) ? NW'(1) :
                        (ncol_ext > NW'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS) : ncol_ext;

   assign mm_lo       = mm_rdata[SW-1:0];
   assign mm_hi       = mm_rdata[2*SW-1:SW];
   assign cur_x       = st_rdata;
   assign x_minus_lo  = {cur_x[SW-1], cur_x} - {mm_lo[SW-1], mm_lo};
   assign hi_minus_lo = {mm_hi[SW-1], mm_hi} - {mm_lo[SW-1], mm_lo};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rp_in         = rp_ff;
      wcol_in       = wcol_ff;
      rcol_in       = rcol_ff;
      pcol_in       = pcol_ff;
      ovf_in        = ovf_ff;
      seen_in       = seen_ff;
      ncol_in       = cfg_write ? pwdata[cms_pkg::CFG_W-1:0] : ncol_ff;
      x_in          = x_ff;
      res_scaled_in = res_scaled_ff;
      res_last_in   = res_last_ff;
      res_flat_in   = res_flat_ff;
      res_empty_in  = res_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_scaled_in = out_scaled_ff;
      out_col_in    = out_col_ff;
      out_last_in   = out_last_ff;
      out_flat_in   = out_flat_ff;
      out_empty_in  = out_empty_ff;
      out_ovf_in    = out_ovf_ff;

      st_we    = 1'b0;
      st_waddr = cnt_ff[SAW-1:0];
      st_wdata = req_chan.sample;
      st_raddr = rp_ff[SAW-1:0];
      mm_we    = 1'b0;
      mm_waddr = pcol_ff;
      mm_wdata = {x_ff, x_ff};
      mm_raddr = (req_chan.cmd == cms_pkg::CMD_PUSH) ? wcol_ff : rcol_ff;
      dv_start = 1'b0;
      dv_num   = x_minus_lo[cms_pkg::QUO_W-1:0];
      dv_den   = hi_minus_lo[cms_pkg::QUO_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.cmd)
                  cms_pkg::CMD_PUSH: begin
                     if (rp_ff != '0 || cnt_ff == CNTW'(MAX_SAMPLES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        st_we   = 1'b1;
                        cnt_in  = cnt_ff + CNTW'(1);
                        x_in    = req_chan.sample;
                        pcol_in = wcol_ff;
                        wcol_in = next_col(wcol_ff, active_cols);
                        if (!seen_ff[wcol_ff]) begin
                           seen_in[wcol_ff] = 1'b1;
                           mm_we    = 1'b1;
                           mm_waddr = wcol_ff;
                           mm_wdata = {req_chan.sample, req_chan.sample};
                        end else begin
                           state_in = ST_PUSH_UPD;
                        end
                     end
                  end
                  cms_pkg::CMD_PULL: begin
                     if (rp_ff >= cnt_ff) begin
                        res_empty_in  = 1'b1;
                        res_scaled_in = '0;
                        res_last_in   = 1'b0;
                        res_flat_in   = 1'b0;
                        pcol_in       = '0;
                        state_in      = ST_EMIT;
                     end else begin
                        res_empty_in  = 1'b0;
                        res_scaled_in = '0;
                        pcol_in       = rcol_ff;
                        res_last_in   = (rp_ff + CNTW'(1) == cnt_ff);
                        res_flat_in   = !seen_ff[rcol_ff];
                        rp_in         = rp_ff + CNTW'(1);
                        rcol_in       = next_col(rcol_ff, active_cols);
                        state_in      = ST_PULL_CMP;
                     end
                  end
                  cms_pkg::CMD_CLEAR: begin
                     cnt_in  = '0;
                     rp_in   = '0;
                     wcol_in = '0;
                     rcol_in = '0;
                     ovf_in  = 1'b0;
                     seen_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PUSH_UPD: begin
            mm_we    = 1'b1;
            mm_waddr = pcol_ff;
            mm_wdata[SW-1:0]    = ($signed(x_ff) < mm_lo) ? x_ff : mm_lo;
            mm_wdata[2*SW-1:SW] = ($signed(x_ff) > mm_hi) ? x_ff : mm_hi;
            state_in = ST_IDLE;
         end
         ST_PULL_CMP: begin
            if (res_flat_ff || mm_hi <= mm_lo) begin
               res_flat_in   = 1'b1;
               res_scaled_in = '0;
               state_in      = ST_EMIT;
            end else if (cur_x <= mm_lo) begin
               res_scaled_in = '0;
               state_in      = ST_EMIT;
            end else if (cur_x >= mm_hi) begin
               res_scaled_in = cms_pkg::SCALED_ONE;
               state_in      = ST_EMIT;
            end else begin
               dv_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dv_done) begin
               res_scaled_in = cms_pkg::SCALED_W'(dv_quo);
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               out_scaled_in = res_scaled_ff;
               out_col_in    = cms_pkg::COL_OUT_W'(pcol_ff);
               out_last_in   = res_last_ff;
               out_flat_in   = res_flat_ff;
               out_empty_in  = res_empty_ff;
               out_ovf_in    = ovf_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rp_ff        <= '0;
         wcol_ff      <= '0;
         rcol_ff      <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= '0;
         ncol_ff      <= cms_pkg::NUM_COLUMNS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rp_ff        <= rp_in;
         wcol_ff      <= wcol_in;
         rcol_ff      <= rcol_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         ncol_ff      <= ncol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcol_ff       <= pcol_in;
      x_ff          <= x_in;
      res_scaled_ff <= res_scaled_in;
      res_last_ff   <= res_last_in;
      res_flat_ff   <= res_flat_in;
      res_empty_ff  <= res_empty_in;
      out_scaled_ff <= out_scaled_in;
      out_col_ff    <= out_col_in;
      out_last_ff   <= out_last_in;
      out_flat_ff   <= out_flat_in;
      out_empty_ff  <= out_empty_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scaled      = out_scaled_ff;
   assign rsp_chan.column      = out_col_ff;
   assign rsp_chan.last        = out_last_ff;
   assign rsp_chan.flat_column = out_flat_ff;
   assign rsp_chan.empty_res   = out_empty_ff;
   assign rsp_chan.overflowed  = out_ovf_ff;

   a_rp_le_cnt: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= cnt_ff)
      else $error("read position beyond stored count");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_SAMPLES))
      else $error("stored count beyond capacity");

   a_late_push: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.cmd == cms_pkg::CMD_PUSH && rp_ff != '0 |=> ovf_ff)
      else $error("push after pull did not set overflow");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      dv_busy |-> state_ff == ST_DIV)
      else $error("divider busy outside divide state");

endmodule
